// ===== rtl/tfw_pkg.sv =====
// Package for the trapezoid flux waveform block: widths, register codes,
// and the word types passed between front end, queue and divider back end.
// No dependencies.
`default_nettype none

package tfw_pkg;

  localparam int PHASE_W = 16;           // input angle width
  localparam int VAL_W   = 15;           // config registers and folded angle
  localparam int OUT_W   = 16;           // signed Q1.14 result
  localparam int NUM_W   = 29;           // product magnitude, max 32767*16384
  localparam int DEN_W   = 15;
  localparam int QUO_W   = 15;           // every quotient stays below 2^15
  localparam int CFG_IDX_W = 2;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [VAL_W-1:0] QUARTER    = 15'd16384;
  localparam logic [VAL_W-1:0] FULL_SCALE = 15'd16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KNEE_LEVEL = 2'd0,
    CFG_RAMP_START = 2'd1,
    CFG_RAMP_END   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [VAL_W-1:0] knee_level;
    logic [VAL_W-1:0] ramp_start;
    logic [VAL_W-1:0] ramp_end;
  } tfw_cfg_t;

  // after segment selection, before the multiply
  typedef struct packed {
    logic             neg;
    logic             q_neg;
    logic [VAL_W-1:0] base;
    logic [VAL_W-1:0] mul_a;
    logic [VAL_W-1:0] mul_b;
    logic [DEN_W-1:0] den;
  } tfw_mul_t;

  // queued word: result = base +/- num/den, then clamp and sign
  typedef struct packed {
    logic             neg;
    logic             q_neg;
    logic [VAL_W-1:0] base;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } tfw_work_t;

  typedef struct packed {
    logic             neg;
    logic             q_neg;
    logic [VAL_W-1:0] base;
    logic [NUM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [QUO_W-1:0] quo;
  } tfw_div_t;

endpackage

`default_nettype wire

// ===== rtl/tfw_front.sv =====
// Front end: folds the angle to a quarter wave, picks the segment and
// forms the numerator product. Two stages. Depends on tfw_pkg.
`default_nettype none

module tfw_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tfw_pkg::tfw_cfg_t               cfg,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [tfw_pkg::PHASE_W-1:0]     in_angle_phase,
  input  logic                            q_full,
  output logic                            q_wr_en,
  output tfw_pkg::tfw_work_t              q_wr_data
);
  import tfw_pkg::*;

  logic             front_en;
  logic [1:0]       quad;
  logic [VAL_W-1:0] fold;
  tfw_mul_t         f1_nxt;
  tfw_mul_t         f1_r;
  logic             f1_valid_r;
  tfw_work_t        f2_r;
  logic             f2_valid_r;
  logic [2*VAL_W-1:0] prod;

  // whole front moves together; only a full queue holds it
  assign front_en = !(f2_valid_r && q_full);
  assign in_stall = !front_en;

  assign quad = in_angle_phase[PHASE_W-1:PHASE_W-2];
  assign fold = quad[0] ? (QUARTER - {1'b0, in_angle_phase[PHASE_W-3:0]})
                        : {1'b0, in_angle_phase[PHASE_W-3:0]};

  always_comb begin
    f1_nxt       = '0;
    f1_nxt.neg   = quad[1];
    f1_nxt.den   = DEN_W'(1);
    priority if (fold < cfg.ramp_start) begin
      // flat zero: 0 / 1 + 0
    end else if (fold < cfg.ramp_end) begin
      f1_nxt.mul_a = cfg.knee_level;
      f1_nxt.mul_b = fold - cfg.ramp_start;
      f1_nxt.den   = cfg.ramp_end - cfg.ramp_start;
    end else if (cfg.ramp_end >= QUARTER) begin
      // empty last segment gives the knee level
      f1_nxt.base  = cfg.knee_level;
    end else begin
      f1_nxt.base  = cfg.knee_level;
      f1_nxt.q_neg = (cfg.knee_level > FULL_SCALE);
      f1_nxt.mul_a = f1_nxt.q_neg ? (cfg.knee_level - FULL_SCALE)
                                  : (FULL_SCALE - cfg.knee_level);
      f1_nxt.mul_b = fold - cfg.ramp_end;
      f1_nxt.den   = QUARTER - cfg.ramp_end;
    end
  end

  assign prod = f1_r.mul_a * f1_r.mul_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
      f2_valid_r <= 1'b0;
    end else if (front_en) begin
      f1_valid_r <= in_valid;
      f2_valid_r <= f1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (front_en) begin
      f1_r       <= f1_nxt;
      f2_r.neg   <= f1_r.neg;
      f2_r.q_neg <= f1_r.q_neg;
      f2_r.base  <= f1_r.base;
      f2_r.num   <= prod[NUM_W-1:0];
      f2_r.den   <= f1_r.den;
    end
  end

  assign q_wr_en   = f2_valid_r && front_en;
  assign q_wr_data = f2_r;

  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (f2_valid_r && q_full))
    else $error("front stalled without a blocked word");

endmodule

`default_nettype wire

// ===== rtl/tfw_queue.sv =====
// Short register FIFO between front end and divider back end.
// Depends on tfw_pkg.
`default_nettype none

module tfw_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  tfw_pkg::tfw_work_t wr_data,
  output logic               full,
  input  logic               rd_en,
  output tfw_pkg::tfw_work_t rd_data,
  output logic               empty
);
  import tfw_pkg::*;

  tfw_work_t            mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r;
  logic [Q_PTR_W-1:0]   rd_ptr_r;
  logic [Q_CNT_W-1:0]   count_r;
  logic [Q_CNT_W-1:0]   count_nxt;

  assign full    = (count_r == Q_CNT_W'(Q_DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    unique case ({wr_en, rd_en})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (rd_en) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !full)
    else $error("queue write while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !empty)
    else $error("queue read while empty");

endmodule

`default_nettype wire

// ===== rtl/tfw_back.sv =====
// Back end: pipelined restoring divider, one quotient bit per stage,
// then base add, clamp, sign and the output register. Depends on tfw_pkg.
`default_nettype none

module tfw_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  tfw_pkg::tfw_work_t            q_rd_data,
  output logic                          q_rd_en,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [tfw_pkg::OUT_W-1:0] out_flux_value
);
  import tfw_pkg::*;

  localparam int CMP_W = NUM_W + 1;
  localparam int SUM_W = VAL_W + 2;
  localparam logic signed [SUM_W-1:0] POS_LIM = SUM_W'(FULL_SCALE);
  localparam logic signed [SUM_W-1:0] NEG_LIM = -POS_LIM;

  logic                      back_en;
  tfw_div_t                  st_r      [QUO_W+1];
  logic                      st_valid_r[QUO_W+1];
  tfw_div_t                  st_nxt    [QUO_W];
  tfw_div_t                  load;
  logic signed [SUM_W-1:0]   base_s;
  logic signed [SUM_W-1:0]   quo_s;
  logic signed [SUM_W-1:0]   sum;
  logic signed [SUM_W-1:0]   mag;
  logic signed [SUM_W-1:0]   res;
  logic                      out_valid_r;
  logic signed [OUT_W-1:0]   out_flux_value_r;

  assign back_en = !out_valid_r || !out_stall;
  assign q_rd_en = back_en && !q_empty;

  always_comb begin
    load       = '0;
    load.neg   = q_rd_data.neg;
    load.q_neg = q_rd_data.q_neg;
    load.base  = q_rd_data.base;
    load.rem   = q_rd_data.num;
    load.den   = q_rd_data.den;
  end

  // stage s decides quotient bit QUO_W-1-s
  always_comb begin
    logic [CMP_W-1:0] dsh;
    logic             ge;
    for (int s = 0; s < QUO_W; s++) begin
      dsh       = CMP_W'(st_r[s].den) << (QUO_W - 1 - s);
      ge        = ({1'b0, st_r[s].rem} >= dsh);
      st_nxt[s] = st_r[s];
      if (ge) begin
        st_nxt[s].rem                = st_r[s].rem - dsh[NUM_W-1:0];
        st_nxt[s].quo[QUO_W - 1 - s] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= QUO_W; i++) st_valid_r[i] <= 1'b0;
    end else if (back_en) begin
      st_valid_r[0] <= !q_empty;
      for (int i = 0; i < QUO_W; i++) st_valid_r[i+1] <= st_valid_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      st_r[0] <= load;
      for (int i = 0; i < QUO_W; i++) st_r[i+1] <= st_nxt[i];
    end
  end

  // truncated quotient carries the segment slope sign
  assign base_s = $signed({2'b00, st_r[QUO_W].base});
  assign quo_s  = $signed({2'b00, st_r[QUO_W].quo});
  assign sum    = st_r[QUO_W].q_neg ? (base_s - quo_s) : (base_s + quo_s);

  always_comb begin
    priority if (sum > POS_LIM) begin
      mag = POS_LIM;
    end else if (sum < NEG_LIM) begin
      mag = NEG_LIM;
    end else begin
      mag = sum;
    end
  end

  assign res = st_r[QUO_W].neg ? -mag : mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (back_en) begin
      out_valid_r <= st_valid_r[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      out_flux_value_r <= res[OUT_W-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_flux_value = out_flux_value_r;

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_flux_value_r <= $signed(OUT_W'(FULL_SCALE)) &&
                     out_flux_value_r >= -$signed(OUT_W'(FULL_SCALE))))
    else $error("flux word outside full scale");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (st_valid_r[QUO_W] == $past(st_valid_r[QUO_W])))
    else $error("divider moved while output held");

endmodule

`default_nettype wire

// ===== rtl/trapezoid_flux_waveform.sv =====
// Trapezoidal flux waveform generator. One angle word in, one signed
// Q1.14 flux word out per accepted word. Throughput is one word per clock
// while no stall holds the flow. Each word passes two front stages (fold
// and segment pick, then the 15x15 multiply), the four-word queue, sixteen
// divider stages (load plus one quotient bit each) and the output register.
// The restoring divider has 15 quotient-bit stages.
// Registers: 0 knee_level, 1 ramp_start, 2 ramp_end; write them only while
// no word is in flight. Depends on tfw_pkg, tfw_front, tfw_queue, tfw_back.
`default_nettype none

module trapezoid_flux_waveform (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [tfw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tfw_pkg::VAL_W-1:0]        cfg_wr_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [tfw_pkg::PHASE_W-1:0]      in_angle_phase,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [tfw_pkg::OUT_W-1:0] out_flux_value
);
  import tfw_pkg::*;

  tfw_cfg_t  cfg_r;
  logic      q_full;
  logic      q_empty;
  logic      q_wr_en;
  logic      q_rd_en;
  tfw_work_t q_wr_data;
  tfw_work_t q_rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.knee_level <= FULL_SCALE;
      cfg_r.ramp_start <= '0;
      cfg_r.ramp_end   <= QUARTER;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_KNEE_LEVEL: cfg_r.knee_level <= cfg_wr_data;
        CFG_RAMP_START: cfg_r.ramp_start <= cfg_wr_data;
        CFG_RAMP_END:   cfg_r.ramp_end   <= cfg_wr_data;
        default:        ;
      endcase
    end
  end

  tfw_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_angle_phase (in_angle_phase),
    .q_full         (q_full),
    .q_wr_en        (q_wr_en),
    .q_wr_data      (q_wr_data)
  );

  tfw_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr_en),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_rd_en),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  tfw_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_rd_data      (q_rd_data),
    .q_rd_en        (q_rd_en),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_flux_value (out_flux_value)
  );

endmodule

`default_nettype wire
